FILE: rtl/sme_pkg.sv
// Package for the stack machine executor: opcode and fault codes.
// Used by the executor and the divider in rtl/; depends on nothing.
package sme_pkg;

  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_PUSH  = 4'd1,
    OP_POP   = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_MUL   = 4'd5,
    OP_DIV   = 4'd6,
    OP_BLT   = 4'd7,
    OP_BGE   = 4'd8,
    OP_DUP   = 4'd9,
    OP_LOAD  = 4'd10,
    OP_STORE = 4'd11,
    OP_END   = 4'd12
  } opcode_t;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_DIV0  = 2'd1,
    FLT_UNDER = 2'd2,
    FLT_OVER  = 2'd3
  } fault_t;

  // Divider request and reply between the control and the divide unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/stack_machine_executor.sv
// Stack machine executor: runs one decoded instruction per accepted word.
// Each accepted word passes through a memory read, then execute with write-back and
// output register load; a branch adds a second read and execute pass to refetch the
// new top, and a divide adds a wait on the iterative divider.
// A new word is taken only once the previous instruction is done (idle, read, execute)
// over the single stack RAM, and not while a stalled result word is still held.
module stack_machine_executor #(
  parameter int STACK_DEPTH = 64,
  parameter int PC_WIDTH    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic signed [31:0] in_operand,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_top_value,
  output logic [6:0]  out_depth,
  output logic [15:0] out_next_pc,
  output logic [1:0]  out_fault,
  output logic        out_halted
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // The sequencer walks each instruction through read, execute and
  // (for divide) a wait on the iterative divider.
  typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_DIVW} state_t;

  state_t state_r;
  logic [CW-1:0]       cnt_r;
  logic [PC_WIDTH-1:0] pc_r;
  logic                halt_r;
  // The top of stack is kept in a register so that results need no extra read.
  logic [31:0]         top_r;
  logic [3:0]          op_r;
  logic [31:0]         arg_r;
  // Set during the extra read pass that refills the top after a branch.
  logic                br_fetch_r;

  logic        ov_r;
  logic [31:0] o_top_r;
  logic [6:0]  o_depth_r;
  logic [15:0] o_pc_r;
  logic [1:0]  o_fault_r;
  logic        o_halt_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] ra_a, ra_b;
  logic [31:0]   rd_a, rd_b;
  logic          we_m;
  logic [AW-1:0] waddr_m;
  logic [31:0]   wdata_m;

  sme_pkg::div_req_t dreq;
  sme_pkg::div_rsp_t drsp;

  sme_stack_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we_m), .waddr(waddr_m), .wdata(wdata_m),
    .raddr_a(ra_a), .raddr_b(ra_b), .rdata_a(rd_a), .rdata_b(rd_b)
  );

  sme_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // A new word is taken only when idle and the output register is not holding
  // a result word that the receiver is stalling.
  assign in_stall = (state_r != S_IDLE) || (ov_r && out_stall);
  logic accept;
  assign accept = in_valid && !in_stall;

  // Read addresses in S_READ: a = entry c-2 (left operand, also the entry below
  // top so a pop can refill the top register), b = entry c-k for load, else c-2.
  // In the branch refill pass cnt_r is already the new count, so port a
  // reads the new top at entry c-1.
  logic [31:0] c32, k32;
  assign c32 = 32'(cnt_r);
  assign k32 = arg_r;

  always_comb begin
    ra_a = br_fetch_r ? AW'(c32 - 32'd1) : AW'(c32 - 32'd2);
    case (op_r)
      sme_pkg::OP_LOAD: ra_b = AW'(c32 - k32);
      default:          ra_b = AW'(c32 - 32'd2);
    endcase
  end

  // Execute-stage evaluation.
  logic [31:0]         b_v, a_v, r_v;
  logic [1:0]          flt;
  logic [CW-1:0]       cnt_n;
  logic [PC_WIDTH-1:0] pc_n, pc1, pc5;
  logic                halt_n, ld_top_mem, is_div;
  logic [31:0]         top_n;
  logic                less;

  assign b_v  = top_r;
  assign a_v  = rd_a;
  assign pc1  = pc_r + PC_WIDTH'(1);
  assign pc5  = pc_r + PC_WIDTH'(5);
  assign less = $signed(a_v) < $signed(b_v);

  always_comb begin
    flt = sme_pkg::FLT_NONE;
    cnt_n = cnt_r;
    pc_n = pc_r;
    halt_n = halt_r;
    top_n = top_r;
    we = 1'b0;
    waddr = AW'(c32);
    wdata = top_r;
    is_div = 1'b0;
    r_v = 32'd0;
    ld_top_mem = 1'b0;
    if (!halt_r) begin
      case (op_r) inside
        sme_pkg::OP_PUSH: begin
          if (c32 >= STACK_DEPTH) flt = sme_pkg::FLT_OVER;
          else begin
            we = 1'b1; waddr = AW'(c32); wdata = arg_r;
            top_n = arg_r; cnt_n = cnt_r + CW'(1); pc_n = pc5;
          end
        end
        sme_pkg::OP_POP: begin
          if (c32 < 1) flt = sme_pkg::FLT_UNDER;
          else begin
            top_n = (c32 >= 2) ? rd_a : 32'd0;
            cnt_n = cnt_r - CW'(1); pc_n = pc1;
          end
        end
        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
          if (c32 < 2) flt = sme_pkg::FLT_UNDER;
          else if (op_r == sme_pkg::OP_DIV && b_v == 32'd0) flt = sme_pkg::FLT_DIV0;
          else if (op_r == sme_pkg::OP_DIV) is_div = 1'b1;
          else begin
            case (op_r)
              sme_pkg::OP_ADD: r_v = a_v + b_v;
              sme_pkg::OP_SUB: r_v = a_v - b_v;
              default:         r_v = a_v * b_v;
            endcase
            we = 1'b1; waddr = AW'(c32 - 32'd2); wdata = r_v;
            top_n = r_v; cnt_n = cnt_r - CW'(1); pc_n = pc1;
          end
        end
        sme_pkg::OP_BLT, sme_pkg::OP_BGE: begin
          if (c32 < 2) flt = sme_pkg::FLT_UNDER;
          else begin
            cnt_n = cnt_r - CW'(2);
            ld_top_mem = 1'b1;
            pc_n = ((op_r == sme_pkg::OP_BLT) == less) ? PC_WIDTH'(arg_r) : pc5;
          end
        end
        sme_pkg::OP_DUP: begin
          if (c32 < 1) flt = sme_pkg::FLT_UNDER;
          else if (c32 >= STACK_DEPTH) flt = sme_pkg::FLT_OVER;
          else begin
            we = 1'b1; waddr = AW'(c32); wdata = top_r;
            cnt_n = cnt_r + CW'(1); pc_n = pc1;
          end
        end
        sme_pkg::OP_LOAD: begin
          if (k32 < 1 || k32 > c32) flt = sme_pkg::FLT_UNDER;
          else if (c32 >= STACK_DEPTH) flt = sme_pkg::FLT_OVER;
          else begin
            // k = 1 reads the top itself, which lives in top_r.
            wdata = (k32 == 32'd1) ? top_r : rd_b;
            we = 1'b1; waddr = AW'(c32);
            top_n = wdata; cnt_n = cnt_r + CW'(1); pc_n = pc5;
          end
        end
        sme_pkg::OP_STORE: begin
          if (c32 < 1 || k32 > c32 - 32'd1) flt = sme_pkg::FLT_UNDER;
          else begin
            we = (k32 != 32'd0); waddr = AW'(c32 - 32'd1 - k32); wdata = top_r;
            cnt_n = cnt_r - CW'(1); pc_n = pc5;
            // The new top is entry c-2; when k = 1 it just received the old top.
            top_n = (c32 < 2) ? 32'd0 : ((k32 == 32'd1) ? top_r : rd_a);
          end
        end
        sme_pkg::OP_END: begin
          halt_n = 1'b1; pc_n = pc1;
        end
        default: pc_n = pc1;
      endcase
    end
    if (state_r != S_EXEC) we = 1'b0;
  end

  // Branches pop two, so the new top is entry c-3; it is fetched in one
  // more read and execute pass through port a.

  assign dreq.start    = (state_r == S_EXEC) && is_div;
  assign dreq.dividend = a_v;
  assign dreq.divisor  = b_v;

  // Divide result write-back: quotient lands in entry c-2.
  logic div_we;
  assign div_we = (state_r == S_DIVW) && drsp.done;

  assign we_m    = (we && !br_fetch_r) || div_we;
  assign waddr_m = div_we ? AW'(c32 - 32'd2) : waddr;
  assign wdata_m = div_we ? drsp.quotient : wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      pc_r       <= '0;
      halt_r     <= 1'b0;
      top_r      <= '0;
      ov_r       <= 1'b0;
      br_fetch_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r  <= in_mode;
            arg_r <= in_operand;
            if (in_restart) begin
              cnt_r  <= '0;
              pc_r   <= '0;
              halt_r <= 1'b0;
              top_r  <= '0;
            end
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_EXEC;
        S_EXEC: begin
          if (is_div) begin
            state_r <= S_DIVW;
          end else if (ld_top_mem && !br_fetch_r) begin
            // Commit the branch, then read entry c-3 (new c-1) as the top.
            cnt_r      <= cnt_n;
            pc_r       <= pc_n;
            br_fetch_r <= 1'b1;
            state_r    <= S_READ;
          end else begin
            if (br_fetch_r) begin
              br_fetch_r <= 1'b0;
              top_r      <= (c32 >= 1) ? rd_a : 32'd0;
              o_top_r    <= (c32 >= 1) ? rd_a : 32'd0;
              o_depth_r  <= 7'(cnt_r);
              o_pc_r     <= 16'(pc_r);
              o_fault_r  <= sme_pkg::FLT_NONE;
              o_halt_r   <= halt_r;
            end else begin
              cnt_r     <= cnt_n;
              pc_r      <= pc_n;
              halt_r    <= halt_n;
              top_r     <= top_n;
              o_top_r   <= (cnt_n == '0) ? 32'd0 : top_n;
              o_depth_r <= 7'(cnt_n);
              o_pc_r    <= 16'(pc_n);
              o_fault_r <= flt;
              o_halt_r  <= halt_n;
            end
            ov_r    <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_DIVW: begin
          if (drsp.done) begin
            top_r     <= drsp.quotient;
            cnt_r     <= cnt_r - CW'(1);
            pc_r      <= pc1;
            o_top_r   <= drsp.quotient;
            o_depth_r <= 7'(cnt_r - CW'(1));
            o_pc_r    <= 16'(pc1);
            o_fault_r <= sme_pkg::FLT_NONE;
            o_halt_r  <= halt_r;
            ov_r      <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = ov_r;
  assign out_top_value = o_top_r;
  assign out_depth     = o_depth_r;
  assign out_next_pc   = o_pc_r;
  assign out_fault     = o_fault_r;
  assign out_halted    = o_halt_r;

endmodule

FILE: rtl/sme_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sme_pkg for the request and reply structs.
module sme_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sme_pkg::div_req_t req,
  output sme_pkg::div_rsp_t rsp
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] den_r;
  logic        neg_r;
  logic        done_r;
  logic [32:0] trial;
  logic [31:0] qnext;

  assign trial = {rem_r, quo_r[31]} - {1'b0, den_r};
  assign qnext = {quo_r[30:0], ~trial[32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == 5'd0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
        rem_r  <= '0;
        quo_r  <= req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
        den_r  <= req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
        neg_r  <= req.dividend[31] ^ req.divisor[31];
      end else if (busy_r) begin
        rem_r <= trial[32] ? {rem_r[30:0], quo_r[31]} : trial[31:0];
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          quo_r  <= neg_r ? 32'd0 - qnext : qnext;
        end else begin
          quo_r <= qnext;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: rtl/sme_stack_ram.sv
// Stack memory: one write port, two synchronous read ports with registered data.
// Depends on nothing beyond its parameters.
module sme_stack_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: bench/sme_checker.sv
// Checker for the stack machine executor: watches both channels, predicts each result word
// and compares it field by field. Depends on sme_pkg.
`timescale 1ns / 100ps
module sme_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_mode,
  input  logic signed [31:0] in_operand,
  input  logic               in_restart,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_top_value,
  input  logic [6:0]         out_depth,
  input  logic [15:0]        out_next_pc,
  input  logic [1:0]         out_fault,
  input  logic               out_halted,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int STACK_DEPTH = 64;

  typedef struct packed {
    logic [31:0] top_value;
    logic [6:0]  depth;
    logic [15:0] next_pc;
    logic [1:0]  fault;
    logic        halted;
  } step_result_t;

  logic [31:0] model_stack [STACK_DEPTH];
  int unsigned model_count;
  logic [15:0] model_pc;
  logic        model_halt;
  step_result_t expected_steps[$];

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  task automatic execute_instruction(logic [3:0] mode, logic [31:0] arg, logic restart);
    int unsigned c;
    logic [1:0] flt;
    logic [31:0] a, b, r;
    logic less;
    step_result_t res;
    flt = sme_pkg::FLT_NONE;
    if (restart) begin
      model_count = 0;
      model_pc = '0;
      model_halt = 1'b0;
    end
    c = model_count;
    if (!model_halt) begin
      case (mode) inside
        sme_pkg::OP_PUSH: begin
          if (c >= STACK_DEPTH) flt = sme_pkg::FLT_OVER;
          else begin
            model_stack[c] = arg;
            model_count = c + 1;
            model_pc = model_pc + 16'd5;
          end
        end
        sme_pkg::OP_POP: begin
          if (c < 1) flt = sme_pkg::FLT_UNDER;
          else begin
            model_count = c - 1;
            model_pc = model_pc + 16'd1;
          end
        end
        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
          if (c < 2) flt = sme_pkg::FLT_UNDER;
          else begin
            a = model_stack[c-2];
            b = model_stack[c-1];
            if (mode == sme_pkg::OP_DIV && b == 0) flt = sme_pkg::FLT_DIV0;
            else begin
              case (mode)
                sme_pkg::OP_ADD: r = a + b;
                sme_pkg::OP_SUB: r = a - b;
                sme_pkg::OP_MUL: r = a * b;
                default:         r = div_trunc(a, b);
              endcase
              model_stack[c-2] = r;
              model_count = c - 1;
              model_pc = model_pc + 16'd1;
            end
          end
        end
        sme_pkg::OP_BLT, sme_pkg::OP_BGE: begin
          if (c < 2) flt = sme_pkg::FLT_UNDER;
          else begin
            less = $signed(model_stack[c-2]) < $signed(model_stack[c-1]);
            model_count = c - 2;
            if ((mode == sme_pkg::OP_BLT) == less) model_pc = arg[15:0];
            else model_pc = model_pc + 16'd5;
          end
        end
        sme_pkg::OP_DUP: begin
          if (c < 1) flt = sme_pkg::FLT_UNDER;
          else if (c >= STACK_DEPTH) flt = sme_pkg::FLT_OVER;
          else begin
            model_stack[c] = model_stack[c-1];
            model_count = c + 1;
            model_pc = model_pc + 16'd1;
          end
        end
        sme_pkg::OP_LOAD: begin
          if (arg < 1 || arg > c) flt = sme_pkg::FLT_UNDER;
          else if (c >= STACK_DEPTH) flt = sme_pkg::FLT_OVER;
          else begin
            model_stack[c] = model_stack[c-arg];
            model_count = c + 1;
            model_pc = model_pc + 16'd5;
          end
        end
        sme_pkg::OP_STORE: begin
          if (c < 1 || arg > c - 1) flt = sme_pkg::FLT_UNDER;
          else begin
            model_stack[c-1-arg] = model_stack[c-1];
            model_count = c - 1;
            model_pc = model_pc + 16'd5;
          end
        end
        sme_pkg::OP_END: begin
          model_halt = 1'b1;
          model_pc = model_pc + 16'd1;
        end
        default: model_pc = model_pc + 16'd1;
      endcase
    end
    res.top_value = (model_count > 0) ? model_stack[model_count-1] : '0;
    res.depth = model_count[6:0];
    res.next_pc = model_pc;
    res.fault = flt;
    res.halted = model_halt;
    expected_steps.push_back(res);
  endtask

  always @(posedge clk) begin
    step_result_t want, got;
    if (!rst_n) begin
      model_count = 0;
      model_pc = '0;
      model_halt = 1'b0;
      expected_steps.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_top_value, out_depth, out_next_pc, out_fault, out_halted};
        if (expected_steps.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("Unexpected result word %h", got);
        end else begin
          want = expected_steps.pop_front();
          if (got !== want) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("Mismatch: top %h/%h depth %0d/%0d pc %h/%h fault %0d/%0d halt %0d/%0d",
                       want.top_value, got.top_value, want.depth, got.depth,
                       want.next_pc, got.next_pc, want.fault, got.fault,
                       want.halted, got.halted);
          end
        end
      end
      if (in_valid && !in_stall) execute_instruction(in_mode, in_operand, in_restart);
    end
    pending_count = expected_steps.size();
  end

endmodule

FILE: bench/tb_stack_machine_executor.sv
// Top of the stack machine executor bench: clock, reset, instruction stimulus and verdict.
// Depends on sme_pkg, stack_machine_executor and sme_checker.
`timescale 1ns / 100ps
module tb_stack_machine_executor;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_mode = '0;
  logic signed [31:0] in_operand = '0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_top_value;
  logic [6:0] out_depth;
  logic [15:0] out_next_pc;
  logic [1:0] out_fault;
  logic out_halted;
  int fail_count, pending_count;

  // Bumped by the stimulus each time the result side should hold off for a long
  // stretch to back the block up; the result side counts the holds it has done.
  int hold_requests = 0;
  int idle_cycles = 0;
  localparam int WATCHDOG_LIMIT = 5000;

  always #1 clk = ~clk;

  stack_machine_executor dut (.*);

  sme_checker checker_i (.*);

  // Watchdog: a run of cycles without any accepted word or taken result means the block hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stall per word, or a long hold when one is requested.
  initial begin
    int gap;
    int holds_done;
    holds_done = 0;
    @(posedge rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      @(negedge clk);
      if (hold_requests != holds_done) begin
        out_stall <= 1'b1;
        // The long hold is counted here, independently of the sender.
        repeat (200) @(negedge clk);
        holds_done = holds_done + 1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one instruction word after the given gap and waits until it is taken.
  task automatic send_word(logic [3:0] mode, logic [31:0] arg, logic restart, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_operand <= arg;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic int rand_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // Pauses the sender until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // A random program: mostly pushes, arithmetic, branches and memory moves, with
  // offsets mostly in range, occasionally out of it, and a rare random opcode.
  task automatic random_program(int len);
    logic [3:0] m;
    logic [31:0] arg;
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) m = sme_pkg::OP_PUSH;
      else if (pick < 97) m = 4'($urandom_range(sme_pkg::OP_POP, sme_pkg::OP_STORE));
      else if (pick < 98) m = sme_pkg::OP_END;
      else m = 4'($urandom_range(0, 15));
      case (m) inside
        sme_pkg::OP_LOAD, sme_pkg::OP_STORE:
          arg = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 8);
        sme_pkg::OP_BLT, sme_pkg::OP_BGE: arg = $urandom();
        default:                          arg = rand_value();
      endcase
      send_word(m, arg, (i == 0) || ($urandom_range(0, 60) == 0), rand_gap());
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: underflow on an empty stack, extremes, each opcode, divide cases.
    send_word(sme_pkg::OP_POP, 0, 1'b0, 0);
    send_word(sme_pkg::OP_ADD, 0, 1'b0, 0);
    send_word(sme_pkg::OP_PUSH, 32'h8000_0000, 1'b0, 0);
    send_word(sme_pkg::OP_PUSH, 32'hffff_ffff, 1'b0, 0);
    send_word(sme_pkg::OP_DIV, 0, 1'b0, 0);
    send_word(sme_pkg::OP_PUSH, 0, 1'b0, 0);
    send_word(sme_pkg::OP_DIV, 0, 1'b0, 0);
    send_word(sme_pkg::OP_PUSH, 32'h7fff_ffff, 1'b0, 0);
    send_word(sme_pkg::OP_PUSH, 7, 1'b0, 0);
    send_word(sme_pkg::OP_MUL, 0, 1'b0, 0);
    send_word(sme_pkg::OP_PUSH, -3, 1'b0, 0);
    send_word(sme_pkg::OP_DIV, 0, 1'b0, 0);
    send_word(sme_pkg::OP_DUP, 0, 1'b0, 0);
    send_word(sme_pkg::OP_SUB, 0, 1'b0, 0);
    send_word(sme_pkg::OP_LOAD, 2, 1'b0, 0);
    send_word(sme_pkg::OP_LOAD, 0, 1'b0, 0);
    send_word(sme_pkg::OP_STORE, 1, 1'b0, 0);
    send_word(sme_pkg::OP_STORE, 32'h8000_0000, 1'b0, 0);
    send_word(sme_pkg::OP_BLT, 32'hffff_fffe, 1'b0, 0);
    send_word(sme_pkg::OP_BGE, 32'h0001_0004, 1'b0, 0);
    send_word(4'd15, 0, 1'b0, 0);
    send_word(sme_pkg::OP_END, 0, 1'b0, 0);
    send_word(sme_pkg::OP_PUSH, 1, 1'b0, 0);
    send_word(sme_pkg::OP_NOP, 0, 1'b1, 0);
    drain_results();

    // Fill the stack to overflow, then probe the top-of-stack faults.
    for (int i = 0; i < 65; i++) send_word(sme_pkg::OP_PUSH, $urandom(), 1'b0, 0);
    send_word(sme_pkg::OP_DUP, 0, 1'b0, 0);
    send_word(sme_pkg::OP_LOAD, 64, 1'b0, 0);
    send_word(sme_pkg::OP_STORE, 63, 1'b0, 0);
    send_word(sme_pkg::OP_LOAD, 63, 1'b0, 0);

    // Back-pressure: the result side holds off while the sender keeps going.
    hold_requests = hold_requests + 1;
    random_program(20);
    drain_results();

    for (int p = 0; p < 25; p++) random_program(16);
    drain_results();

    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
